// ===== hw/rtl/qepp_pkg.sv =====
// Shared package for the quad equal-power panner.
// Holds widths, register and corner codes, controller/datapath structs and the pan ROM.
// No dependencies; every other file in the block imports it.
package qepp_pkg;

	// Field and port widths.
	localparam int SAMPLE_W    = 16;
	localparam int GAIN_W      = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_DATA_W   = 3 * SAMPLE_W;
	localparam int OUT_DATA_W  = 4 * SAMPLE_W;
	localparam int NUM_CORNERS = 4;
	localparam int CORNER_W    = 2;
	localparam logic [CFG_DATA_W-1:0] DIVIDE_RESET = 16'd48;

	// Pan table geometry.
	localparam int PAN_TABLE_SIZE = 256;
	localparam int PAN_IDX_W      = $clog2(PAN_TABLE_SIZE);
	localparam int CORDIC_STEPS   = 30;
	localparam longint PAN_DEN    = 10 * (PAN_TABLE_SIZE - 1);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_JOYSTICK_X     = 2'd0,
		CFG_JOYSTICK_Y     = 2'd1,
		CFG_CONTROL_DIVIDE = 2'd2
	} cfg_reg_t;

	// Corner order of the gain and product registers.
	typedef enum logic [CORNER_W-1:0] {
		CORNER_FL = 2'd0,
		CORNER_FR = 2'd1,
		CORNER_SL = 2'd2,
		CORNER_SR = 2'd3
	} corner_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;       // take the input transfer, step the divider
		logic    index_en;   // register both axis table indexes
		logic    lookup_en;  // register the four axis gains
		logic    gain_en;    // write one corner gain
		logic    scale_en;   // write one scaled sample
		corner_t sel;        // corner addressed in the gain and scale steps
		logic    out_load;   // move the four products into the output register
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic wrap;      // the divider wraps on the sample now offered
		logic out_free;  // the output register can take a new result this cycle
	} ctrl_status_t;

	// Q2.30 arctangent steps of the vectoring rotation.
	localparam longint ATAN_Q30 [CORDIC_STEPS] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
		64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
		64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
		64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
	};

	// One pan table entry: min(1, atan(1.7 t)) in Q0.16, evaluated at elaboration.
	function automatic logic [GAIN_W-1:0] pan_entry(input int i);
		longint x;
		longint y;
		longint z;
		longint g;
		longint xs;
		longint ys;
		x = longint'(1) <<< 30;
		y = (longint'(17) * longint'(i) * (longint'(1) <<< 30) + PAN_DEN / 2) / PAN_DEN;
		z = 0;
		for (int k = 0; k < CORDIC_STEPS; k++) begin
			xs = x >>> k;
			ys = y >>> k;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_Q30[k];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_Q30[k];
			end
		end
		g = (z + (longint'(1) <<< 13)) >>> 14;
		if (g < 0)
			g = 0;
		if (g > 65535)
			g = 65535;
		return GAIN_W'(g);
	endfunction

	typedef logic [GAIN_W-1:0] pan_rom_t [PAN_TABLE_SIZE];

	function automatic pan_rom_t build_pan_rom();
		pan_rom_t r;
		for (int i = 0; i < PAN_TABLE_SIZE; i++)
			r[i] = pan_entry(i);
		return r;
	endfunction

	localparam pan_rom_t PAN_ROM = build_pan_rom();

endpackage

// ===== hw/rtl/qepp_ctrl.sv =====
// Controller of the quad equal-power panner: sequences one item at a time.
// Drives the datapath through ctrl_cmd_t and reads ctrl_status_t; uses qepp_pkg.
module qepp_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  qepp_pkg::ctrl_status_t status,
	output qepp_pkg::ctrl_cmd_t    cmd
);
	import qepp_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_INDEX  = 6'b000010,
		ST_LOOKUP = 6'b000100,
		ST_GAIN   = 6'b001000,
		ST_SCALE  = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t              state_q;
	state_t              state_d;
	logic [CORNER_W-1:0] step_q;
	logic [CORNER_W-1:0] step_d;
	logic                last_step;

	assign last_step = (step_q == CORNER_W'(NUM_CORNERS - 1));
	assign s_tready  = (state_q == ST_IDLE);

	// Next state and commands.
	always_comb begin
		state_d       = state_q;
		step_d        = step_q;
		cmd           = '0;
		cmd.sel       = corner_t'(step_q);
		unique case (state_q)
			ST_IDLE: begin
				step_d = '0;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = status.wrap ? ST_INDEX : ST_SCALE;
				end
			end
			ST_INDEX: begin
				cmd.index_en = 1'b1;
				state_d      = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				cmd.lookup_en = 1'b1;
				state_d       = ST_GAIN;
			end
			ST_GAIN: begin
				cmd.gain_en = 1'b1;
				step_d      = step_q + 1'b1;
				if (last_step)
					state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale_en = 1'b1;
				step_d       = step_q + 1'b1;
				if (last_step)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	// A wrapping sample must run the gain update before it is scaled.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && status.wrap |=> state_q == ST_INDEX)
		else $error("wrapping sample skipped the gain update");

	// The last corner gain is followed by scaling from the first corner.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_GAIN && last_step |=> state_q == ST_SCALE && step_q == '0)
		else $error("gain update did not hand over to scaling");

endmodule

// ===== hw/rtl/qepp_datapath.sv =====
// Datapath of the quad equal-power panner: registers, divider, pan lookup, shared multiplier.
// Obeys ctrl_cmd_t from qepp_ctrl; uses qepp_pkg for widths and the pan ROM.
module qepp_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [qepp_pkg::IN_DATA_W-1:0]       s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [qepp_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [qepp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [qepp_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  qepp_pkg::ctrl_cmd_t                  cmd,
	output qepp_pkg::ctrl_status_t               status
);
	import qepp_pkg::*;

	localparam int NUM_W = SAMPLE_W + PAN_IDX_W + 1;
	localparam int MUL_W = GAIN_W + 1;
	localparam int PROD_W = 2 * MUL_W;

	logic signed [SAMPLE_W-1:0] joy_x_q;
	logic signed [SAMPLE_W-1:0] joy_y_q;
	logic [CFG_DATA_W-1:0]      divide_q;
	logic [CFG_DATA_W-1:0]      count_q;
	logic [CFG_DATA_W:0]        count_next;

	logic signed [SAMPLE_W-1:0] sample_q;
	logic signed [SAMPLE_W-1:0] xcv_q;
	logic signed [SAMPLE_W-1:0] ycv_q;
	logic [PAN_IDX_W-1:0]       idx_x_q;
	logic [PAN_IDX_W-1:0]       idx_y_q;
	logic [GAIN_W-1:0]          g_left_q;
	logic [GAIN_W-1:0]          g_right_q;
	logic [GAIN_W-1:0]          g_front_q;
	logic [GAIN_W-1:0]          g_surr_q;
	logic [GAIN_W-1:0]          corner_gain_q [NUM_CORNERS];
	logic [SAMPLE_W-1:0]        prod_q [NUM_CORNERS];
	logic                       m_tvalid_q;
	logic [OUT_DATA_W-1:0]      m_tdata_q;

	logic [GAIN_W-1:0]          op_a;
	logic [GAIN_W-1:0]          op_b;
	logic signed [MUL_W-1:0]    mul_a;
	logic signed [MUL_W-1:0]    mul_b;
	logic signed [PROD_W-1:0]   mul_p;
	logic signed [PROD_W-17:0]  mul_shift;
	logic [SAMPLE_W-1:0]        mul_sat;

	// Position on one axis mapped to a pan table index, rounded to nearest.
	function automatic logic [PAN_IDX_W-1:0] axis_index(
		input logic signed [SAMPLE_W-1:0] joy,
		input logic signed [SAMPLE_W-1:0] cv
	);
		logic signed [SAMPLE_W+1:0] sum;
		logic [SAMPLE_W-1:0]        pos;
		logic [NUM_W-1:0]           num;
		logic [NUM_W-17:0]          quo;
		logic [16:0]                rem;
		sum = {{2{joy[SAMPLE_W-1]}}, joy} + {cv[SAMPLE_W-1], cv, 1'b0};
		if (sum > 18'sd32767)
			pos = 16'h7FFF;
		else if (sum < -18'sd32768)
			pos = 16'h8000;
		else
			pos = sum[SAMPLE_W-1:0];
		// Offset binary 0..65535, then scale by the last table index.
		num = NUM_W'({1'b0, ~pos[SAMPLE_W-1], pos[SAMPLE_W-2:0]})
			* NUM_W'(PAN_TABLE_SIZE - 1) + NUM_W'(32767);
		// Divide by 65535: the shift by 16 is low by at most one.
		quo = num[NUM_W-1:16];
		rem = {1'b0, num[15:0]} + 17'(quo);
		if (rem >= 17'd65535)
			quo = quo + 1'b1;
		return PAN_IDX_W'(quo);
	endfunction

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joy_x_q  <= '0;
			joy_y_q  <= '0;
			divide_q <= DIVIDE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_JOYSTICK_X:     joy_x_q  <= cfg_data;
				CFG_JOYSTICK_Y:     joy_y_q  <= cfg_data;
				CFG_CONTROL_DIVIDE: divide_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Control-rate divider.
	assign count_next  = {1'b0, count_q} + 1'b1;
	assign status.wrap = (count_next >= {1'b0, divide_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (cmd.load)
			count_q <= status.wrap ? '0 : count_next[CFG_DATA_W-1:0];
	end

	// Input capture, index and lookup registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= s_tdata[SAMPLE_W-1:0];
			xcv_q    <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
			ycv_q    <= s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
		end
		if (cmd.index_en) begin
			idx_x_q <= axis_index(joy_x_q, xcv_q);
			idx_y_q <= axis_index(joy_y_q, ycv_q);
		end
		if (cmd.lookup_en) begin
			g_right_q <= PAN_ROM[idx_x_q];
			g_left_q  <= PAN_ROM[PAN_IDX_W'(PAN_TABLE_SIZE - 1) - idx_x_q];
			g_front_q <= PAN_ROM[idx_y_q];
			g_surr_q  <= PAN_ROM[PAN_IDX_W'(PAN_TABLE_SIZE - 1) - idx_y_q];
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		unique case (cmd.sel)
			CORNER_FL: begin op_a = g_left_q;  op_b = g_front_q; end
			CORNER_FR: begin op_a = g_right_q; op_b = g_front_q; end
			CORNER_SL: begin op_a = g_left_q;  op_b = g_surr_q;  end
			CORNER_SR: begin op_a = g_right_q; op_b = g_surr_q;  end
			default:   begin op_a = g_left_q;  op_b = g_front_q; end
		endcase
	end

	assign mul_a = cmd.scale_en ? {sample_q[SAMPLE_W-1], sample_q} : {1'b0, op_a};
	assign mul_b = cmd.scale_en ? {1'b0, corner_gain_q[cmd.sel]} : {1'b0, op_b};
	assign mul_p = mul_a * mul_b;

	// Floor shift by 16 and saturation of a scaled sample.
	assign mul_shift = mul_p[PROD_W-1:16];
	always_comb begin
		if (mul_shift > (PROD_W-16)'(32767))
			mul_sat = 16'h7FFF;
		else if (mul_shift < -(PROD_W-16)'(32768))
			mul_sat = 16'h8000;
		else
			mul_sat = mul_shift[SAMPLE_W-1:0];
	end

	// Corner gains start at zero, so outputs are silent before the first update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CORNERS; k++)
				corner_gain_q[k] <= '0;
		end else if (cmd.gain_en) begin
			corner_gain_q[cmd.sel] <= mul_p[31:16];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scale_en)
			prod_q[cmd.sel] <= mul_sat;
	end

	// Output register; the next item is worked on while it waits.
	assign status.out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (cmd.out_load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load)
			m_tdata_q <= {prod_q[CORNER_SR], prod_q[CORNER_SL],
				prod_q[CORNER_FR], prod_q[CORNER_FL]};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// A result is never written over one that has not been taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !m_tvalid_q || m_tready)
		else $error("output register overwritten");

	// A wrapping sample leaves the divider at zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && status.wrap |=> count_q == '0)
		else $error("divider did not restart on wrap");

endmodule

// ===== hw/rtl/quad_equal_power_panner.sv =====
// Quad equal-power panner: each sample is scaled to the four corners, first updating the corner gains
// when the divider wraps. One item is worked on at a time; the single shared multiplier
// runs the four corner gains and the four scaled samples one after another.
// The output register holds a result while the next item is processed.
// Reset (arst_n low, asynchronous) clears gains and divider, joysticks to 0, divide to 48.
// Depends on qepp_pkg, qepp_ctrl and qepp_datapath.
module quad_equal_power_panner (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [15:0] signal_sample, [31:16] x_control, [47:32] y_control
	input  logic [qepp_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [15:0] front_left, [31:16] front_right, [47:32] surround_left, [63:48] surround_right
	output logic [qepp_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [qepp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [qepp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import qepp_pkg::*;

	ctrl_cmd_t    cmd;
	ctrl_status_t status;

	// Sequencer.
	qepp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Registers, lookup and arithmetic.
	qepp_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status)
	);

endmodule
